>>> rtl/bras_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bras_pkg
// Shared types, codes and helper functions of the bitmap RAM access unit.
// ----------------------------------------------------------------------------
package bras_pkg;

    localparam int ADDR_W  = 14;
    localparam int BANK_W  = 12;   // each RAM is split in two banks on address bit 8
    localparam int COLOR_W = 5;
    localparam int SLOT_W  = 6;
    localparam int RGB_W   = 9;
    localparam int BANK_DEPTH = 4096;

    typedef logic [1:0]         t_req;
    typedef logic [BANK_W-1:0]  t_bank_addr;

    localparam t_req REQ_VID_RD = 2'd0;
    localparam t_req REQ_VID_WR = 2'd1;
    localparam t_req REQ_COL_RD = 2'd2;
    localparam t_req REQ_COL_WR = 2'd3;

    localparam logic CFG_SHIFT = 1'b0;
    localparam logic CFG_MODE  = 1'b1;

    localparam logic [3:0] ALU_DS_XM      = 4'd0;
    localparam logic [3:0] ALU_OR_XM      = 4'd1;
    localparam logic [3:0] ALU_XM_AND     = 4'd2;
    localparam logic [3:0] ALU_ZERO       = 4'd3;
    localparam logic [3:0] ALU_AND_XM     = 4'd4;
    localparam logic [3:0] ALU_D0_XM      = 4'd5;
    localparam logic [3:0] ALU_XOR        = 4'd6;
    localparam logic [3:0] ALU_AND_NDM    = 4'd7;
    localparam logic [3:0] ALU_XM_OR      = 4'd8;
    localparam logic [3:0] ALU_XNOR_M     = 4'd9;
    localparam logic [3:0] ALU_D0         = 4'd10;
    localparam logic [3:0] ALU_AND        = 4'd11;
    localparam logic [3:0] ALU_MASK       = 4'd12;
    localparam logic [3:0] ALU_OR_NDM     = 4'd13;
    localparam logic [3:0] ALU_OR         = 4'd14;
    localparam logic [3:0] ALU_DS         = 4'd15;

    function automatic logic [15:0] alu16(input logic [3:0] op, input logic [15:0] ds,
                                          input logic [15:0] d0, input logic [15:0] m);
        logic [15:0] r;
        case (op)
            ALU_DS_XM:   r = ds ^ m;
            ALU_OR_XM:   r = (ds | d0) ^ m;
            ALU_XM_AND:  r = (ds ^ m) & d0;
            ALU_ZERO:    r = '0;
            ALU_AND_XM:  r = (ds & d0) ^ m;
            ALU_D0_XM:   r = d0 ^ m;
            ALU_XOR:     r = ds ^ d0;
            ALU_AND_NDM: r = ds & (d0 ^ m);
            ALU_XM_OR:   r = (ds ^ m) | d0;
            ALU_XNOR_M:  r = (ds ^ d0) ^ m;
            ALU_D0:      r = d0;
            ALU_AND:     r = ds & d0;
            ALU_MASK:    r = m;
            ALU_OR_NDM:  r = ds | (d0 ^ m);
            ALU_OR:      r = ds | d0;
            default:     r = ds;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7-i] = v[i];
        return r;
    endfunction

    function automatic logic [RGB_W-1:0] pal_value(input logic [COLOR_W-1:0] cl,
                                                   input logic [COLOR_W-1:0] cr);
        return {cl[1:0], cr[3:0], cl[4:2]};
    endfunction

endpackage

>>> rtl/bras_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bras_req_if
// Request channel: bus access type, address and write data.
// ----------------------------------------------------------------------------
interface bras_req_if;
    logic                         valid;
    logic                         ready;
    bras_pkg::t_req               req_type;
    logic [bras_pkg::ADDR_W-1:0]  bus_address;
    logic [7:0]                   write_byte;

    modport source (output valid, req_type, bus_address, write_byte, input ready);
    modport sink   (input valid, req_type, bus_address, write_byte, output ready);
endinterface

>>> rtl/bras_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bras_rsp_if
// Response channel: read data and palette update report.
// ----------------------------------------------------------------------------
interface bras_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    read_byte;
    logic                          palette_updated;
    logic [bras_pkg::SLOT_W-1:0]   palette_slot;
    logic [bras_pkg::RGB_W-1:0]    palette_rgb;

    modport source (output valid, read_byte, palette_updated, palette_slot, palette_rgb,
                    input ready);
    modport sink   (input valid, read_byte, palette_updated, palette_slot, palette_rgb,
                    output ready);
endinterface

>>> rtl/bitmap_ram_shift_alu_access_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_ram_shift_alu_access_core
// CPU-side access unit for bitmap video RAM and color RAM with shifter,
// mirror, logic ALU, protect/roll handling and palette update.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one bus access per transaction (video/color, read/write).
//   o_rsp returns exactly one transaction per request: read data, and the
//   palette slot and value when a low-row color access refreshed the palette.
//   i_cfg_we/i_cfg_idx/i_cfg_data write shift_control (0) and mode_control (1);
//   write them only while no request is in flight.
// Sequence:
//   A request is accepted in the idle cycle, both RAM banks are read on that
//   edge, and in S_EXEC the unit modifies, writes back and loads the response
//   register. A new request is taken only after the previous one has been
//   written back; the response stays valid until it is taken.
// Reset:
//   After i_rst_n the video and color RAMs are swept to zero, one row of all
//   four banks per cycle; i_req.ready stays low until every row is cleared.
// Stall:
//   The response register holds a finished transaction; the next request is
//   still accepted, but its write-back waits until the held one is taken.
// ----------------------------------------------------------------------------
module bitmap_ram_shift_alu_access_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bras_req_if.sink            i_req,
    bras_rsp_if.source          o_rsp,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [bras_pkg::BANK_W-1:0]  r_clr_cnt;
    logic [7:0]                   r_shc, r_mode;
    logic [bras_pkg::COLOR_W-1:0] r_cc, n_cc;

    // Held request
    bras_pkg::t_req               r_type;
    logic [bras_pkg::ADDR_W-1:0]  r_addr;
    logic [7:0]                   r_wdata;
    bras_pkg::t_bank_addr         r_ia, r_ib;

    // Banks: A holds address bit 8 clear, B holds bit 8 set
    logic [7:0]                   mem_bm_a [bras_pkg::BANK_DEPTH];
    logic [7:0]                   mem_bm_b [bras_pkg::BANK_DEPTH];
    logic [bras_pkg::COLOR_W-1:0] mem_cl_a [bras_pkg::BANK_DEPTH];
    logic [bras_pkg::COLOR_W-1:0] mem_cl_b [bras_pkg::BANK_DEPTH];
    logic [7:0]                   r_bm_a_q, r_bm_b_q;
    logic [bras_pkg::COLOR_W-1:0] r_cl_a_q, r_cl_b_q;

    logic                         accept, exec_go, clearing;
    bras_pkg::t_bank_addr         ia, ib, wa, wb;
    logic                         bm_we_a, bm_we_b, cl_we_a, cl_we_b;
    logic [7:0]                   bm_wd_a, bm_wd_b;
    logic [bras_pkg::COLOR_W-1:0] cl_wd_a, cl_wd_b;

    // Response register
    logic                         r_ov;
    logic [7:0]                   r_rd, n_rd;
    logic                         r_upd, n_upd;
    logic [bras_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic [bras_pkg::RGB_W-1:0]   r_rgb, n_rgb;

    assign clearing    = (r_state == S_CLEAR);
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_ov || o_rsp.ready);

    // Bank addresses: the pair at bit 8 clear/set shares one row, except a
    // video window starting at bit 8 set, whose partner is in the next row.
    always_comb begin
        ib = {i_req.bus_address[12:9], i_req.bus_address[7:0]};
        ia = ib;
        if (!i_req.req_type[1] && i_req.bus_address[8]) begin
            ia = {i_req.bus_address[12:9] + 4'd1, i_req.bus_address[7:0]};
        end
    end

    // Control and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_shc     <= '0;
            r_mode    <= '0;
            r_cc      <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cc    <= n_cc;
            if (clearing) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cfg_we) begin
                if (i_cfg_idx == bras_pkg::CFG_SHIFT) r_shc <= i_cfg_data;
                else                                  r_mode <= i_cfg_data;
            end
            if (exec_go)          r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr_cnt) n_state = S_IDLE;
            S_IDLE:  if (accept)     n_state = S_EXEC;
            S_EXEC:  if (exec_go)    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type  <= i_req.req_type;
            r_addr  <= i_req.bus_address;
            r_wdata <= i_req.write_byte;
            r_ia    <= ia;
            r_ib    <= ib;
        end
    end

    // Memories
    assign wa = clearing ? r_clr_cnt : r_ia;
    assign wb = clearing ? r_clr_cnt : r_ib;

    always_ff @(posedge i_clk) begin
        if (bm_we_a) mem_bm_a[wa] <= bm_wd_a;
        if (accept)  r_bm_a_q     <= mem_bm_a[ia];
    end
    always_ff @(posedge i_clk) begin
        if (bm_we_b) mem_bm_b[wb] <= bm_wd_b;
        if (accept)  r_bm_b_q     <= mem_bm_b[ib];
    end
    always_ff @(posedge i_clk) begin
        if (cl_we_a) mem_cl_a[wa] <= cl_wd_a;
        if (accept)  r_cl_a_q     <= mem_cl_a[ia];
    end
    always_ff @(posedge i_clk) begin
        if (cl_we_b) mem_cl_b[wb] <= cl_wd_b;
        if (accept)  r_cl_b_q     <= mem_cl_b[ib];
    end

    // Modify
    logic                         upper, lr, hold, pal_en, hi_in_b, protect, low_row;
    logic [2:0]                   sh;
    logic [15:0]                  m, ds, d0, res;
    logic [7:0]                   dm, hi_b, lo_b, vd;
    logic [15:0]                  vrot;
    logic [bras_pkg::COLOR_W-1:0] cl, cr, c_one, c_sel;

    always_comb begin
        upper   = r_addr[13];
        sh      = upper ? r_shc[3:1] : r_shc[7:5];
        lr      = upper ? r_shc[0]   : r_shc[4];
        hold    = r_mode[7];
        pal_en  = r_mode[6];
        hi_in_b = r_addr[8];
        low_row = (r_addr[7:5] == 3'd0);
        protect = low_row && !r_mode[5];

        m = 16'hff00 >> sh;
        if (&r_addr[12:8]) m = m & (r_mode[4] ? 16'h00ff : 16'hff00);

        hi_b = hi_in_b ? r_bm_b_q : r_bm_a_q;
        lo_b = hi_in_b ? r_bm_a_q : r_bm_b_q;
        d0   = {hi_b, lo_b};
        dm   = lr ? bras_pkg::mirror8(r_wdata) : r_wdata;
        ds   = ({dm, 8'h00} >> sh) & m;
        res  = (d0 & ~m) | bras_pkg::alu16(~r_mode[3:0], ds, d0 & m, m);

        vd   = (hi_b & m[15:8]) | (lo_b & m[7:0]);
        vrot = {vd, vd} << sh;

        cl    = hold ? r_cc : r_wdata[4:0];
        cr    = {hold ? r_cc[4] : r_wdata[4], r_addr[8], r_wdata[7:5]};
        c_one = hi_in_b ? r_cl_b_q : r_cl_a_q;
        c_sel = r_type[0] ? cl : r_cl_a_q;

        n_cc   = r_cc;
        n_rd   = '0;
        n_upd  = 1'b0;
        n_slot = '0;
        n_rgb  = '0;
        bm_we_a = clearing;
        bm_we_b = clearing;
        cl_we_a = clearing;
        cl_we_b = clearing;
        bm_wd_a = '0;
        bm_wd_b = '0;
        cl_wd_a = '0;
        cl_wd_b = '0;

        if (exec_go) begin
            case (r_type)
                bras_pkg::REQ_VID_RD: begin
                    n_rd = vrot[15:8];
                end
                bras_pkg::REQ_VID_WR: begin
                    if (!protect) begin
                        bm_we_a = 1'b1;
                        bm_we_b = 1'b1;
                        bm_wd_a = hi_in_b ? res[7:0]  : res[15:8];
                        bm_wd_b = hi_in_b ? res[15:8] : res[7:0];
                        if (!upper && !hold) begin
                            cl_wd_a = r_cc;
                            cl_wd_b = r_cc;
                            cl_we_a = hi_in_b ? (|m[7:0])  : (|m[15:8]);
                            cl_we_b = hi_in_b ? (|m[15:8]) : (|m[7:0]);
                        end
                    end
                end
                default: begin
                    if (low_row) begin
                        if (r_type[0]) begin
                            cl_we_a = 1'b1;
                            cl_we_b = 1'b1;
                            cl_wd_a = cl;
                            cl_wd_b = cr;
                            n_cc    = cl;
                        end else begin
                            n_rd = {r_cl_b_q[2:0], r_cl_a_q};
                        end
                        if (pal_en) begin
                            n_upd  = 1'b1;
                            n_slot = {r_addr[9], r_addr[4:0]};
                            n_rgb  = bras_pkg::pal_value(c_sel,
                                                         r_type[0] ? cr : r_cl_b_q);
                        end
                    end else if (r_type[0]) begin
                        cl_we_a = !hi_in_b;
                        cl_we_b = hi_in_b;
                        cl_wd_a = cl;
                        cl_wd_b = cl;
                        n_cc    = cl;
                    end else begin
                        n_rd = {3'b000, c_one};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_rd   <= n_rd;
            r_upd  <= n_upd;
            r_slot <= n_slot;
            r_rgb  <= n_rgb;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.read_byte       = r_rd;
    assign o_rsp.palette_updated = r_upd;
    assign o_rsp.palette_slot    = r_slot;
    assign o_rsp.palette_rgb     = r_rgb;

    // Checks
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !i_req.ready) else $error("request taken during RAM clear");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC)) else $error("accept did not start execution");
    a_exec_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |=> o_rsp.valid) else $error("finished request gave no response");
    a_pal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.palette_updated) |->
        (o_rsp.palette_slot == '0 && o_rsp.palette_rgb == '0))
        else $error("palette fields set without update");

endmodule
